// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/pkvlp_pkg.sv =====
// ---------------------------------------------------------------------------
// pkvlp_pkg
// types, codes and character helper of the key=value line parser
// ---------------------------------------------------------------------------
package pkvlp_pkg;

	typedef enum logic [4:0] {
		PH_BEFORE = 5'b00001,
		PH_TYPE   = 5'b00010,
		PH_GAP    = 5'b00100,
		PH_KEY    = 5'b01000,
		PH_VALUE  = 5'b10000
	} phase_t;

	typedef enum logic [2:0] {
		ROLE_DROP  = 3'd0,
		ROLE_TYPE  = 3'd1,
		ROLE_KEY   = 3'd2,
		ROLE_VALUE = 3'd3,
		ROLE_EOL   = 3'd4
	} role_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_BAD_TYPE  = 3'd2,
		ST_TOO_MANY  = 3'd3,
		ST_NO_EQUALS = 3'd4,
		ST_EMPTY_KEY = 3'd5
	} status_t;

	localparam logic [7:0] CH_PIPE = 8'h7C;
	localparam logic [7:0] CH_EQ   = 8'h3D;
	localparam logic [7:0] CH_US   = 8'h5F;
	localparam logic [7:0] POS_MAX = 8'hFF;

	typedef struct packed {
		role_t       role;
		logic [3:0]  field_index;
		logic [7:0]  char_pos;
		logic [7:0]  byte_out;
		status_t     status;
		logic [4:0]  num_fields;
	} result_t;

	function automatic logic type_char_ok(input logic [7:0] b);
		return b inside {[8'h41:8'h5A], [8'h30:8'h39], CH_US};
	endfunction

endpackage

// ===== hdl/pkvlp_step.sv =====
// ---------------------------------------------------------------------------
// pkvlp_step
// per-request parse step: next parser state and the tagged result
// ---------------------------------------------------------------------------
module pkvlp_step #(
	parameter int MAX_FIELDS = 16,
	parameter int TYPE_KEEP  = 31,
	parameter int KEY_KEEP   = 31,
	parameter int VALUE_KEEP = 63,
	parameter int FW         = $clog2(MAX_FIELDS + 1)
) (
	input  logic                kind,
	input  logic [7:0]          data,
	input  pkvlp_pkg::phase_t   phase,
	input  logic [FW-1:0]       fields_done,
	input  logic [7:0]          token_pos,
	input  pkvlp_pkg::status_t  err,
	output pkvlp_pkg::phase_t   phase_nxt,
	output logic [FW-1:0]       fields_nxt,
	output logic [7:0]          token_pos_nxt,
	output pkvlp_pkg::status_t  err_nxt,
	output pkvlp_pkg::result_t  res
);
	import pkvlp_pkg::*;

	logic [7:0] fd_ext;
	logic       tag_en;
	logic       tag_restart;
	role_t      tag_role;
	logic [3:0] tag_field;
	logic [7:0] tag_keep;
	logic [7:0] pos_base;
	status_t    st;

	assign fd_ext = 8'(fields_done);

	always_comb begin
		phase_nxt     = phase;
		fields_nxt    = fields_done;
		token_pos_nxt = token_pos;
		err_nxt       = err;
		res           = '0;
		tag_en        = 1'b0;
		tag_restart   = 1'b0;
		tag_role      = ROLE_DROP;
		tag_field     = 4'd0;
		tag_keep      = 8'(TYPE_KEEP);
		pos_base      = token_pos;
		st            = err;

		if (kind) begin
			if (err == ST_OK) begin
				if (phase == PH_BEFORE)
					st = ST_EMPTY;
				else if (phase == PH_KEY)
					st = ST_NO_EQUALS;
			end
			res.role       = ROLE_EOL;
			res.status     = st;
			res.num_fields = (st == ST_OK) ? fd_ext[4:0] : 5'd0;
			phase_nxt      = PH_BEFORE;
			fields_nxt     = '0;
			token_pos_nxt  = '0;
			err_nxt        = ST_OK;
		end else begin
			res.byte_out = data;
			if (err == ST_OK) begin
				case (phase)
					PH_BEFORE: begin
						if (data != CH_PIPE) begin
							if (!type_char_ok(data)) begin
								err_nxt = ST_BAD_TYPE;
							end else begin
								phase_nxt   = PH_TYPE;
								tag_en      = 1'b1;
								tag_restart = 1'b1;
								tag_role    = ROLE_TYPE;
								tag_keep    = 8'(TYPE_KEEP);
							end
						end
					end
					PH_TYPE: begin
						if (data == CH_PIPE) begin
							phase_nxt = PH_GAP;
						end else if (!type_char_ok(data)) begin
							err_nxt = ST_BAD_TYPE;
						end else begin
							tag_en   = 1'b1;
							tag_role = ROLE_TYPE;
							tag_keep = 8'(TYPE_KEEP);
						end
					end
					PH_GAP: begin
						if (data != CH_PIPE) begin
							if (fd_ext >= 8'(MAX_FIELDS)) begin
								err_nxt = ST_TOO_MANY;
							end else if (data == CH_EQ) begin
								err_nxt = ST_EMPTY_KEY;
							end else begin
								phase_nxt   = PH_KEY;
								tag_en      = 1'b1;
								tag_restart = 1'b1;
								tag_role    = ROLE_KEY;
								tag_field   = fd_ext[3:0];
								tag_keep    = 8'(KEY_KEEP);
							end
						end
					end
					PH_KEY: begin
						if (data == CH_PIPE) begin
							err_nxt = ST_NO_EQUALS;
						end else if (data == CH_EQ) begin
							fields_nxt    = FW'(fields_done + 1'b1);
							phase_nxt     = PH_VALUE;
							token_pos_nxt = '0;
						end else begin
							tag_en    = 1'b1;
							tag_role  = ROLE_KEY;
							tag_field = fd_ext[3:0];
							tag_keep  = 8'(KEY_KEEP);
						end
					end
					PH_VALUE: begin
						if (data == CH_PIPE) begin
							phase_nxt = PH_GAP;
						end else begin
							tag_en    = 1'b1;
							tag_role  = ROLE_VALUE;
							tag_field = 4'(fd_ext - 8'd1);
							tag_keep  = 8'(VALUE_KEEP);
						end
					end
					default: begin
						phase_nxt = PH_BEFORE;
					end
				endcase

				// position tagging with saturating counter
				if (tag_en) begin
					pos_base = tag_restart ? 8'd0 : token_pos;
					if (pos_base < tag_keep) begin
						res.role        = tag_role;
						res.field_index = tag_field;
						res.char_pos    = pos_base;
					end
					token_pos_nxt = (pos_base == POS_MAX) ? POS_MAX : 8'(pos_base + 8'd1);
				end
			end
		end
	end

endmodule

// ===== hdl/pipe_key_value_line_parser.sv =====
// ---------------------------------------------------------------------------
// pipe_key_value_line_parser
// Parses a line of the form TYPE|key=value|key=value, one request per byte.
// Input channel (in_valid/in_ready): kind 0 carries a line byte in data,
// kind 1 closes the line. Output channel (out_valid/out_ready): exactly one
// result per input request, in order, giving the byte's role, field index,
// position and the byte itself; on end of line role is end-of-line and
// status/num_fields report the outcome.
// A request goes from the input register to the result register.
// Throughput: one request per cycle unless out_ready stalls; the per-byte
// step is a single compare and phase-update pass between these registers.
// in_ready follows out_ready through the two stages, so a stalled receiver
// holds both registers and backs up the input after two requests.
// Reset clears both stages and returns the parser to the start of a line;
// the parser also returns there after every end-of-line request.
// ---------------------------------------------------------------------------
module pipe_key_value_line_parser #(
	parameter int MAX_FIELDS = 16,
	parameter int TYPE_KEEP  = 31,
	parameter int KEY_KEEP   = 31,
	parameter int VALUE_KEEP = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       kind,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] role,
	output logic [3:0] field_index,
	output logic [7:0] char_pos,
	output logic [7:0] byte_out,
	output logic [2:0] status,
	output logic [4:0] num_fields
);
	import pkvlp_pkg::*;

	localparam int FW = $clog2(MAX_FIELDS + 1);

	logic          valid_s1;
	logic          kind_s1;
	logic [7:0]    data_s1;
	logic          valid_s2;
	result_t       res_s2;

	phase_t        phase_q;
	logic [FW-1:0] fields_q;
	logic [7:0]    token_pos_q;
	status_t       err_q;

	phase_t        phase_nxt;
	logic [FW-1:0] fields_nxt;
	logic [7:0]    token_pos_nxt;
	status_t       err_nxt;
	result_t       res_nxt;

	logic          adv_s2;
	logic          step_fire;

	assign adv_s2    = !valid_s2 || out_ready;
	assign step_fire = valid_s1 && adv_s2;
	assign in_ready  = !valid_s1 || adv_s2;

	pkvlp_step #(
		.MAX_FIELDS (MAX_FIELDS),
		.TYPE_KEEP  (TYPE_KEEP),
		.KEY_KEEP   (KEY_KEEP),
		.VALUE_KEEP (VALUE_KEEP),
		.FW         (FW)
	) u_step (
		.kind          (kind_s1),
		.data          (data_s1),
		.phase         (phase_q),
		.fields_done   (fields_q),
		.token_pos     (token_pos_q),
		.err           (err_q),
		.phase_nxt     (phase_nxt),
		.fields_nxt    (fields_nxt),
		.token_pos_nxt (token_pos_nxt),
		.err_nxt       (err_nxt),
		.res           (res_nxt)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= kind;
			data_s1 <= data;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BEFORE;
			fields_q    <= '0;
			token_pos_q <= '0;
			err_q       <= ST_OK;
		end else if (step_fire) begin
			phase_q     <= phase_nxt;
			fields_q    <= fields_nxt;
			token_pos_q <= token_pos_nxt;
			err_q       <= err_nxt;
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign role        = res_s2.role;
	assign field_index = res_s2.field_index;
	assign char_pos    = res_s2.char_pos;
	assign byte_out    = res_s2.byte_out;
	assign status      = res_s2.status;
	assign num_fields  = res_s2.num_fields;

`include "assert_macros.svh"

	`ASSERT_IMPL(a_byte_no_status, valid_s2 && res_s2.role != ROLE_EOL, res_s2.status == ST_OK && res_s2.num_fields == 5'd0)
	`ASSERT_IMPL(a_err_no_count, valid_s2 && res_s2.role == ROLE_EOL && res_s2.status != ST_OK, res_s2.num_fields == 5'd0)
	`ASSERT_NEXT(a_eol_restart, step_fire && kind_s1, phase_q == PH_BEFORE && fields_q == '0 && err_q == ST_OK)
	`ASSERT_NEXT(a_err_sticky, step_fire && !kind_s1 && err_q != ST_OK, $stable(err_q))

endmodule
